// File: sv/tost_pkg.sv
// Package for the timed output slot table: sizes, command codes, item and
// slot types, sequencer states and the output bit helper.
// No dependencies.
package tost_pkg;

    localparam int SLOTS     = 4;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int OUTPUTS   = 8;
    localparam int OUT_W     = 3;
    localparam int MS_PER_S  = 1000;

    typedef enum logic [1:0] {
        OP_ACTIVATE   = 2'd0,
        OP_DEACTIVATE = 2'd1,
        OP_DEACT_ALL  = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  relay;
        logic [15:0] seconds;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] relay_mask;
        logic       pushed;
    } out_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] outp;
        logic [31:0]      off_time;
    } slot_entry_t;

    function automatic logic [OUTPUTS-1:0] bit_of(input logic [OUT_W-1:0] n);
        logic [OUTPUTS-1:0] m;
        m    = '0;
        m[n] = 1'b1;
        return m;
    endfunction

endpackage

// File: sv/tost_if.sv
// Valid/ready channels of the timed output slot table.
// Depends on tost_pkg for the item types.
interface tost_in_if;
    logic                valid;
    logic                ready;
    tost_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tost_out_if;
    logic                valid;
    logic                ready;
    tost_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/timed_output_slot_table_core.sv
// Timed output slot table: top level with slot memory and sequencer.
// Depends on tost_pkg and the channels in tost_if.sv.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  in_ch   | in  | op, relay, seconds, now_ms       | valid/ready
//  out_ch  | out | relay_mask, pushed               | valid/ready
//
// Every item walks the slot memory one slot at a time through its single
// read port, evaluates the last read data, writes back at commit and then
// loads the output register. The next item is taken only in the idle state
// that follows, so each item reaches the output register before another.
// rst_n clears the sequencer, the slot valid bits and the output mask; the
// slot memory itself is not cleared since free slots are never read for data.
// A stalled output holds its result; input is taken again as soon as the
// result sits in the output register, even before it is taken downstream.
module timed_output_slot_table_core (
    input  logic         clk,
    input  logic         rst_n,
    tost_in_if.sink      in_ch,
    tost_out_if.source   out_ch
);
    import tost_pkg::*;

    // sequencer
    state_t state_reg, state_next;

    // current item and its precomputed off time
    in_item_t    item_reg;
    logic [31:0] off_reg;

    // slot memory: output number and off time, one read or write a cycle
    slot_entry_t slot_mem [SLOTS];
    slot_entry_t rd_reg;
    logic        mem_re;
    logic        mem_we;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;

    // walk counters: issue side and evaluate side (registered from the issue side)
    logic [CNT_W-1:0]  iss_cnt_reg;
    logic              ev_vld_reg;
    logic [SLOT_W-1:0] ev_idx_reg;
    logic              scan_done;

    // slot valid bits and the output mask live in flops
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [OUTPUTS-1:0] mask_reg, mask_next;

    // scan results
    logic               match_hit_reg;
    logic [SLOT_W-1:0]  match_idx_reg;
    logic               exp_hit_reg;
    logic [SLOT_W-1:0]  exp_idx_reg;
    logic [OUT_W-1:0]   exp_out_reg;
    logic [31:0]        best_dist_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [OUT_W-1:0]   best_out_reg;
    logic [OUTPUTS-1:0] clr_mask_reg;

    // evaluation of the slot just read
    logic        ev_slot_valid;
    logic        ev_rel_hit;
    logic        ev_expired;
    logic [31:0] ev_dist;

    // result waiting for the output register, and the output register
    out_item_t res_reg, res_next;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic in_fire;
    logic out_load;
    logic out_free;

    // commit helpers
    logic               rel_ok;
    logic [OUT_W-1:0]   rel_num;
    logic [OUTPUTS-1:0] rel_bit;
    logic               free_hit;
    logic [SLOT_W-1:0]  free_idx;
    logic [SLOT_W-1:0]  pos;
    logic [OUTPUTS-1:0] evict_bit;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = (state_reg == ST_PUSH) && out_free;

    assign rd_addr   = iss_cnt_reg[SLOT_W-1:0];
    assign scan_done = ev_vld_reg && (ev_idx_reg == SLOT_W'(SLOTS - 1));

    assign rel_ok  = (item_reg.relay[3] == 1'b0);
    assign rel_num = item_reg.relay[OUT_W-1:0];
    assign rel_bit = bit_of(rel_num);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
                state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ch.ready = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ch.ready = 1'b1;
            ST_SCAN:   mem_re = (iss_cnt_reg < CNT_W'(SLOTS));
            ST_COMMIT: mem_we = (item_reg.op == OP_ACTIVATE) && rel_ok;
            ST_PUSH:   ;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Item capture; off time = now + seconds * 1000, wrapping 32 bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_ch.data;
            off_reg  <= in_ch.data.now_ms
                      + (32'(in_ch.data.seconds) * 32'(MS_PER_S));
        end
    end

    // ------------------------------------------------------------------
    // Slot memory. Reads happen only while walking, writes only at commit,
    // so a read never overlaps a write to the same entry.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_reg <= slot_mem[rd_addr];
    end

    // walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg <= '0;
            ev_vld_reg  <= 1'b0;
            ev_idx_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                iss_cnt_reg <= '0;
            else if (mem_re)
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            ev_vld_reg <= mem_re;
            ev_idx_reg <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Evaluate the slot read in the cycle before
    // ------------------------------------------------------------------
    assign ev_slot_valid = valid_reg[ev_idx_reg];
    assign ev_rel_hit    = ev_slot_valid && (rd_reg.outp == rel_num);
    assign ev_expired    = ev_slot_valid && (rd_reg.off_time <= item_reg.now_ms);
    assign ev_dist       = rd_reg.off_time - item_reg.now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_hit_reg <= 1'b0;
            exp_hit_reg   <= 1'b0;
            clr_mask_reg  <= '0;
        end
        else if (in_fire)
        begin
            match_hit_reg <= 1'b0;
            exp_hit_reg   <= 1'b0;
            clr_mask_reg  <= '0;
        end
        else if (ev_vld_reg)
        begin
            // keep the first slot serving the relay
            if (ev_rel_hit && !match_hit_reg)
                match_hit_reg <= 1'b1;
            // keep the first expired slot
            if (ev_expired && !exp_hit_reg)
                exp_hit_reg <= 1'b1;
            if (ev_slot_valid)
                clr_mask_reg <= clr_mask_reg | bit_of(rd_reg.outp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_vld_reg)
        begin
            if (ev_rel_hit && !match_hit_reg)
                match_idx_reg <= ev_idx_reg;
            if (ev_expired && !exp_hit_reg)
            begin
                exp_idx_reg <= ev_idx_reg;
                exp_out_reg <= rd_reg.outp;
            end
            // soonest off time; strict compare keeps the lowest slot on ties
            if ((ev_idx_reg == '0) || (ev_dist < best_dist_reg))
            begin
                best_dist_reg <= ev_dist;
                best_idx_reg  <= ev_idx_reg;
                best_out_reg  <= rd_reg.outp;
            end
        end
    end

    // ------------------------------------------------------------------
    // Commit: first free slot, then the update for each command
    // ------------------------------------------------------------------
    always_comb
    begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign evict_bit = free_hit ? '0 : bit_of(best_out_reg);

    always_comb
    begin
        valid_next = valid_reg;
        mask_next  = mask_reg;
        res_next   = '0;
        pos        = free_hit ? free_idx : best_idx_reg;
        wr_addr    = pos;
        wr_data    = '{outp: rel_num, off_time: off_reg};
        case (item_reg.op)
            OP_ACTIVATE:
            begin
                if (rel_ok)
                begin
                    if (((mask_reg & rel_bit) != '0) && match_hit_reg)
                    begin
                        // refresh the off time of the slot already serving it
                        wr_addr = match_idx_reg;
                    end
                    else
                    begin
                        // claim a free slot or evict the soonest one
                        valid_next[pos]  = 1'b1;
                        mask_next        = (mask_reg & ~evict_bit) | rel_bit;
                        res_next.pushed  = 1'b1;
                    end
                end
            end
            OP_DEACTIVATE:
            begin
                if (rel_ok)
                begin
                    if (match_hit_reg)
                        valid_next[match_idx_reg] = 1'b0;
                    mask_next       = mask_reg & ~rel_bit;
                    res_next.pushed = 1'b1;
                end
            end
            OP_DEACT_ALL:
            begin
                valid_next      = '0;
                mask_next       = mask_reg & ~clr_mask_reg;
                res_next.pushed = 1'b1;
            end
            OP_TICK:
            begin
                if (exp_hit_reg)
                begin
                    valid_next[exp_idx_reg] = 1'b0;
                    mask_next       = mask_reg & ~bit_of(exp_out_reg);
                    res_next.pushed = 1'b1;
                end
            end
            default:
            begin
                res_next.pushed = 1'b0;
            end
        endcase
        res_next.relay_mask = mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mask_reg  <= '0;
        end
        else if (state_reg == ST_COMMIT)
        begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT)
            res_reg <= res_next;
        if (out_load)
            out_reg <= res_reg;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

// File: sv/tost_checker.sv
// Port-level checks for the timed output slot table, bound to the top level.
// Depends on timed_output_slot_table_core and its channel ports.
module tost_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_mask,
    input logic       out_pushed
);
    logic [7:0] last_mask_reg;

    // track the mask of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_mask_reg <= '0;
        else if (out_valid && out_ready)
            last_mask_reg <= out_mask;
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mask) && $stable(out_pushed))
        else $error("stalled result changed or dropped");

    // one item at a time: no item right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is at work");

    // an item that pushes nothing leaves the mask as it was
    a_no_push_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_pushed |-> out_mask == last_mask_reg)
        else $error("mask changed without a push");

    // a result never rises straight after an item is accepted
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared in the cycle after acceptance");

endmodule

bind timed_output_slot_table_core tost_checker u_tost_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_mask   (out_ch.data.relay_mask),
    .out_pushed (out_ch.data.pushed)
);
